// ----- rtl/event_repeat_rate_limiter_macros.svh -----
// ----------------------------------------------------------------------------
// event repeat rate limiter assertion macros
// shared property templates for the rate limiter checks
// ----------------------------------------------------------------------------
`ifndef EVENT_REPEAT_RATE_LIMITER_MACROS_SVH
`define EVENT_REPEAT_RATE_LIMITER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ERRL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ERRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/errl_pkg.sv -----
// ----------------------------------------------------------------------------
// errl_pkg
// types and constants of the event repeat rate limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package errl_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [15:0] WILDCARD_SUB        = 16'hFFFF;
	localparam logic [31:0] DEFAULT_INTERVAL_RST = 32'd1000;

	typedef enum logic [1:0] {
		MODE_CHECK  = 2'd0,
		MODE_SET_IV = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_APPEND,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [15:0] fault;
		logic [15:0] sub;
	} key_t;

	typedef struct packed {
		logic [31:0] last_time;
		logic [31:0] suppressed;
		logic [31:0] interval;
	} data_t;

	localparam int KEY_W  = $bits(key_t);
	localparam int DATA_W = $bits(data_t);

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             key_we;
		logic             data_we;
		logic [IDX_W-1:0] wr_addr;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/errl_evt_if.sv -----
// ----------------------------------------------------------------------------
// errl_evt_if
// request channel: one event, interval update, query or clear per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface errl_evt_if
	import errl_pkg::*;
();
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [15:0]        fault_key;
	logic signed [15:0] sub_id;
	logic [31:0]        now_ms;
	logic [31:0]        new_iv;

	modport source (output valid, mode, fault_key, sub_id, now_ms, new_iv, input ready);
	modport sink   (input valid, mode, fault_key, sub_id, now_ms, new_iv, output ready);
endinterface

`default_nettype wire

// ----- rtl/errl_res_if.sv -----
// ----------------------------------------------------------------------------
// errl_res_if
// result channel: one verdict and count per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface errl_res_if;
	logic        valid;
	logic        ready;
	logic        allow;
	logic [31:0] suppressed_count;

	modport source (output valid, allow, suppressed_count, input ready);
	modport sink   (input valid, allow, suppressed_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/errl_ram.sv -----
// ----------------------------------------------------------------------------
// errl_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module errl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                         wr_data,
	input  wire logic                                     rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

`default_nettype wire

// ----- rtl/errl_ctrl.sv -----
// ----------------------------------------------------------------------------
// errl_ctrl
// sequencer: scans the key table, updates or appends the entry, returns result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module errl_ctrl
	import errl_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	errl_evt_if.sink          evt,
	errl_res_if.source        res,
	input  wire logic [31:0]  dflt_iv,
	input  wire key_t         key_rd,
	input  wire data_t        data_rd,
	output mem_ctl_t          mem_ctl,
	output key_t              key_wr,
	output data_t             data_wr
);
	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [15:0]       fid_q;
	logic [15:0]       sid_q;
	logic [31:0]       now_q;
	logic [31:0]       iv_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  idx_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              res_allow_q;
	logic [31:0]       res_cnt_q;
	logic              out_vld_q;
	logic              out_allow_q;
	logic [31:0]       out_cnt_q;

	logic              accept;
	logic              match;
	logic              issue;
	logic              scan_done;
	logic              full;
	logic              out_load;
	logic [31:0]       elapsed;
	logic              due;

	assign accept    = evt.valid && evt.ready;
	assign match     = (state_q == ST_SCAN) && cmp_vld_s1 && (key_rd.fault == fid_q) &&
	                   ((mode_q == MODE_SET_IV) || (key_rd.sub == WILDCARD_SUB) ||
	                    (key_rd.sub == sid_q));
	assign issue     = (state_q == ST_SCAN) && !match && (idx_q < used_q);
	assign scan_done = !cmp_vld_s1 && !(idx_q < used_q);
	assign full      = (used_q == CNT_W'(TABLE_ENTRIES));
	assign out_load  = (state_q == ST_RESP) && (!out_vld_q || res.ready);
	assign elapsed   = now_q - data_rd.last_time;
	assign due       = (elapsed >= data_rd.interval);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt.valid) begin
					state_d = (mode_t'(evt.mode) == MODE_CLEAR) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_UPDATE;
				end else if (scan_done) begin
					state_d = ST_APPEND;
				end
			end
			ST_UPDATE: state_d = ST_RESP;
			ST_APPEND: state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		evt.ready       = 1'b0;
		mem_ctl.rd_en   = issue;
		mem_ctl.rd_addr = idx_q[IDX_W-1:0];
		mem_ctl.key_we  = 1'b0;
		mem_ctl.data_we = 1'b0;
		mem_ctl.wr_addr = used_q[IDX_W-1:0];
		key_wr.fault    = fid_q;
		key_wr.sub      = sid_q;
		data_wr         = data_rd;
		unique case (state_q)
			ST_IDLE: evt.ready = 1'b1;
			ST_SCAN: ;
			ST_UPDATE: begin
				mem_ctl.wr_addr = hit_idx_q;
				case (mode_q)
					MODE_CHECK: begin
						mem_ctl.data_we = 1'b1;
						if (due) begin
							data_wr.last_time  = now_q;
							data_wr.suppressed = '0;
						end else begin
							data_wr.suppressed = data_rd.suppressed + 32'd1;
						end
					end
					MODE_SET_IV: begin
						mem_ctl.data_we  = 1'b1;
						data_wr.interval = iv_q;
					end
					default: ;
				endcase
			end
			ST_APPEND: begin
				case (mode_q)
					MODE_CHECK: begin
						mem_ctl.key_we  = !full;
						mem_ctl.data_we = !full;
						data_wr.last_time  = now_q;
						data_wr.suppressed = '0;
						data_wr.interval   = dflt_iv;
					end
					MODE_SET_IV: begin
						mem_ctl.key_we  = !full;
						mem_ctl.data_we = !full;
						key_wr.sub         = WILDCARD_SUB;
						data_wr.last_time  = '0;
						data_wr.suppressed = '0;
						data_wr.interval   = iv_q;
					end
					default: ;
				endcase
			end
			ST_RESP: ;
			default: ;
		endcase
	end

	// state register, entry count and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q      <= '0;
				cmp_vld_s1 <= 1'b0;
				if (mode_t'(evt.mode) == MODE_CLEAR) begin
					used_q <= '0;
				end
			end else if (state_q == ST_SCAN) begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (mem_ctl.key_we) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(evt.mode);
			fid_q  <= evt.fault_key;
			sid_q  <= evt.sub_id;
			now_q  <= evt.now_ms;
			iv_q   <= evt.new_iv;
			res_allow_q <= 1'b0;
			res_cnt_q   <= '0;
		end
		if (issue) begin
			cmp_idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (match) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			res_allow_q <= (mode_q == MODE_CHECK) && due;
			res_cnt_q   <= (mode_q == MODE_QUERY) ? data_rd.suppressed : 32'd0;
		end
		if (state_q == ST_APPEND) begin
			// a check with no entry always passes, even with the table full
			res_allow_q <= (mode_q == MODE_CHECK);
			res_cnt_q   <= '0;
		end
		if (out_load) begin
			out_allow_q <= res_allow_q;
			out_cnt_q   <= res_cnt_q;
		end
	end

	// output register parts the result beat from the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign res.valid            = out_vld_q;
	assign res.allow            = out_allow_q;
	assign res.suppressed_count = out_cnt_q;
endmodule

`default_nettype wire

// ----- rtl/event_repeat_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// event_repeat_rate_limiter
// per-key event repeat limiter over a key table and an entry data table
// ----------------------------------------------------------------------------
// scan: a miss reads every used entry before the result beat, a hit stops at
//   the matching entry, and a clear skips the scan and goes straight to the result
// throughput: one request at a time, bound by the key memory scan at one
//   entry per cycle; a result may wait in the output register meanwhile
// reset: entry count cleared, default interval 1000, table memories not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "event_repeat_rate_limiter_macros.svh"

module event_repeat_rate_limiter
	import errl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	errl_evt_if.sink         evt,
	errl_res_if.source       res
);
	logic [31:0] dflt_iv_q;
	mem_ctl_t    mem_ctl;
	key_t        key_rd;
	key_t        key_wr;
	data_t       data_rd;
	data_t       data_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_iv_q <= DEFAULT_INTERVAL_RST;
		end else if (cfg_we) begin
			dflt_iv_q <= cfg_wdata;
		end
	end

	errl_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (mem_ctl.key_we),
		.wr_addr (mem_ctl.wr_addr),
		.wr_data (key_wr),
		.rd_en   (mem_ctl.rd_en),
		.rd_addr (mem_ctl.rd_addr),
		.rd_data (key_rd)
	);

	errl_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_ENTRIES)
	) u_data_ram (
		.clk     (clk),
		.wr_en   (mem_ctl.data_we),
		.wr_addr (mem_ctl.wr_addr),
		.wr_data (data_wr),
		.rd_en   (mem_ctl.rd_en),
		.rd_addr (mem_ctl.rd_addr),
		.rd_data (data_rd)
	);

	errl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.res     (res),
		.dflt_iv (dflt_iv_q),
		.key_rd  (key_rd),
		.data_rd (data_rd),
		.mem_ctl (mem_ctl),
		.key_wr  (key_wr),
		.data_wr (data_wr)
	);

	// writes never overlap the scan reads
	`ERRL_ASSERT_IMPL(a_wr_no_rd, clk, arst_n, mem_ctl.data_we, !mem_ctl.rd_en, "write during scan")
	// a new key always comes with its entry data
	`ERRL_ASSERT_IMPL(a_key_with_data, clk, arst_n, mem_ctl.key_we, mem_ctl.data_we, "key without data")
	// one request in flight at a time
	`ERRL_ASSERT_NEXT(a_one_inflight, clk, arst_n, evt.valid && evt.ready, !evt.ready, "second beat taken")
endmodule

`default_nettype wire
